### rtl/quaternion_to_euler_defines.svh
// ----------------------------------------------------------------------------
// quaternion_to_euler_defines
// Assertion macros shared by the quaternion to Euler block.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_DEFINES_SVH
`define QUATERNION_TO_EULER_DEFINES_SVH
`ifndef ASSERT_OFF
`define Q2E_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m failed");
`define Q2E_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("%m failed");
`else
`define Q2E_ASSERT(label, clk, rst, prop)
`define Q2E_ASSERT_NR(label, clk, prop)
`endif
`endif

### rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types and constants for the quaternion to Euler angle block.
// ----------------------------------------------------------------------------
`default_nettype none
package q2e_pkg;
   localparam int QuatBits    = 16;
   localparam int CordicSteps = 25;
   localparam int AngFrac     = 12;
   localparam int OpW         = 64;   // CORDIC datapath width
   localparam int AngW        = 34;   // angle accumulator width
   localparam logic signed [AngW-1:0] Ang180 = 34'sd73728000;
   localparam logic signed [OpW-1:0]  GainQ20 = 64'sd1726753;
   localparam int FifoDepth   = 4;
   localparam int FifoAw      = 2;

   // classified word passed from front to back
   typedef struct packed {
      logic               degen;
      logic signed [36:0] roll_y;
      logic signed [36:0] roll_x;
      logic signed [36:0] yaw_y;
      logic signed [36:0] yaw_x;
      logic signed [36:0] pitch_t;
   } work_type;

   function automatic logic signed [AngW-1:0] atan_entry(input int i);
      case (i)
         0: atan_entry = 34'sd18432000;  1: atan_entry = 34'sd10881045;
         2: atan_entry = 34'sd5749245;   3: atan_entry = 34'sd2918407;
         4: atan_entry = 34'sd1464867;   5: atan_entry = 34'sd733147;
         6: atan_entry = 34'sd366663;    7: atan_entry = 34'sd183343;
         8: atan_entry = 34'sd91673;     9: atan_entry = 34'sd45837;
         10: atan_entry = 34'sd22918;    11: atan_entry = 34'sd11459;
         12: atan_entry = 34'sd5730;     13: atan_entry = 34'sd2865;
         14: atan_entry = 34'sd1432;     15: atan_entry = 34'sd716;
         16: atan_entry = 34'sd358;      17: atan_entry = 34'sd179;
         18: atan_entry = 34'sd90;       19: atan_entry = 34'sd45;
         20: atan_entry = 34'sd22;       21: atan_entry = 34'sd11;
         22: atan_entry = 34'sd6;        23: atan_entry = 34'sd3;
         24: atan_entry = 34'sd1;
         default: atan_entry = '0;
      endcase
   endfunction
endpackage
`default_nettype wire

### rtl/q2e_front.sv
// ----------------------------------------------------------------------------
// q2e_front
// Takes quaternion words and forms the atan2 operands over two stages.
// ----------------------------------------------------------------------------
`default_nettype none
module q2e_front import q2e_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [QuatBits-1:0]  req_quat_w,
   input  wire logic signed [QuatBits-1:0]  req_quat_x,
   input  wire logic signed [QuatBits-1:0]  req_quat_y,
   input  wire logic signed [QuatBits-1:0]  req_quat_z,
   output logic                             out_valid,
   input  wire logic                        out_stall,
   output work_type                         out_word
);
   // stage 1: products
   logic        s1_valid_ff, s1_degen_ff;
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff, wx_ff, yz_ff, wz_ff, xy_ff, wy_ff, zx_ff;
   logic        s2_valid_ff;
   work_type    s2_word_ff;
   logic        adv1, adv2;

   assign adv2      = !s2_valid_ff || !out_stall;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;
   assign out_valid = s2_valid_ff;
   assign out_word  = s2_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= req_valid;
      end
      if (adv1) begin
         s1_degen_ff <= (req_quat_w == '0) && (req_quat_x == '0) &&
                        (req_quat_y == '0) && (req_quat_z == '0);
         ww_ff <= req_quat_w * req_quat_w;  xx_ff <= req_quat_x * req_quat_x;
         yy_ff <= req_quat_y * req_quat_y;  zz_ff <= req_quat_z * req_quat_z;
         wx_ff <= req_quat_w * req_quat_x;  yz_ff <= req_quat_y * req_quat_z;
         wz_ff <= req_quat_w * req_quat_z;  xy_ff <= req_quat_x * req_quat_y;
         wy_ff <= req_quat_w * req_quat_y;  zx_ff <= req_quat_z * req_quat_x;
      end
   end

   // stage 2: sums
   logic signed [36:0] n2;
   work_type word_in;
   always_comb begin
      n2 = 37'(ww_ff) + 37'(xx_ff) + 37'(yy_ff) + 37'(zz_ff);
      word_in.degen   = s1_degen_ff;
      word_in.roll_y  = (37'(wx_ff) + 37'(yz_ff)) <<< 1;
      word_in.roll_x  = n2 - ((37'(xx_ff) + 37'(yy_ff)) <<< 1);
      word_in.yaw_y   = (37'(wz_ff) + 37'(xy_ff)) <<< 1;
      word_in.yaw_x   = n2 - ((37'(yy_ff) + 37'(zz_ff)) <<< 1);
      word_in.pitch_t = (37'(wy_ff) - 37'(zx_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv2) s2_word_ff <= word_in;
   end
endmodule
`default_nettype wire

### rtl/q2e_fifo.sv
// ----------------------------------------------------------------------------
// q2e_fifo
// Short queue between front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quaternion_to_euler_defines.svh"
module q2e_fifo import q2e_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     wr_valid,
   output logic          wr_stall,
   input  wire work_type wr_word,
   output logic          rd_valid,
   input  wire logic     rd_stall,
   output work_type      rd_word
);
   work_type             mem_ff [FifoDepth];
   logic [FifoAw-1:0]    wp_ff, rp_ff;
   logic [FifoAw:0]      cnt_ff;
   logic                 push, pop;

   assign wr_stall = (cnt_ff == (FifoAw+1)'(FifoDepth));
   assign rd_valid = (cnt_ff != '0);
   assign rd_word  = mem_ff[rp_ff];
   assign push     = wr_valid && !wr_stall;
   assign pop      = rd_valid && !rd_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (FifoAw+1)'(push) - (FifoAw+1)'(pop);
      end
      if (push) mem_ff[wp_ff] <= wr_word;
   end

   `Q2E_ASSERT(a_no_overflow, clock, reset, cnt_ff <= (FifoAw+1)'(FifoDepth))
   `Q2E_ASSERT(a_full_stalls, clock, reset, (cnt_ff == (FifoAw+1)'(FifoDepth)) |-> wr_stall)
   `Q2E_ASSERT(a_cnt_track, clock, reset, (push && !pop && !$past(reset)) |=> cnt_ff == $past(cnt_ff) + 1'b1)
endmodule
`default_nettype wire

### rtl/q2e_back.sv
// ----------------------------------------------------------------------------
// q2e_back
// Pipelined CORDIC vectoring for roll, yaw and pitch, then rounding.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quaternion_to_euler_defines.svh"
module q2e_back import q2e_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_stall,
   input  wire work_type            in_word,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [15:0]       rsp_roll_angle,
   output logic signed [14:0]       rsp_pitch_angle,
   output logic signed [15:0]       rsp_yaw_angle,
   output logic                     rsp_degenerate
);
   // Stages: 0 prep roll/yaw, 1..25 roll/yaw steps, 26 pitch prep (gain
   // multiply), 27 pitch quadrant, 28..52 pitch steps, 53 output hold.
   // Pitch arrays are indexed from stage 26.
   localparam int NSt = 2*CordicSteps + 4;
   localparam int PSt = CordicSteps + 3;
   logic                   v_ff     [NSt];
   logic                   dg_ff    [NSt];
   logic                   rzero_ff [NSt], yzero_ff [NSt];
   logic signed [36:0]     t_ff     [CordicSteps+1];
   logic signed [OpW-1:0]  rx_ff    [CordicSteps+1], ry_ff [CordicSteps+1];
   logic signed [OpW-1:0]  yx_ff    [CordicSteps+1], yy_ff [CordicSteps+1];
   logic signed [AngW-1:0] rz_ff    [NSt], yz_ff [NSt];
   logic signed [OpW-1:0]  px_ff    [CordicSteps+2], py_ff [CordicSteps+2];
   logic signed [AngW-1:0] pz_ff    [PSt];
   logic                   pzero_ff [PSt];
   logic signed [OpW-1:0]  rx_op, ry_op, yx_op, yy_op;
   logic                   adv;

   // whole pipe moves together; bubbles are kept
   assign adv      = !v_ff[NSt-1] || !rsp_stall;
   assign in_stall = !adv;

   // operands scaled by 2^24
   assign rx_op = OpW'(in_word.roll_x) <<< 24;
   assign ry_op = OpW'(in_word.roll_y) <<< 24;
   assign yx_op = OpW'(in_word.yaw_x)  <<< 24;
   assign yy_op = OpW'(in_word.yaw_y)  <<< 24;

   function automatic logic signed [AngW-1:0] quad_z(input logic signed [OpW-1:0] y,
                                                     input logic signed [OpW-1:0] x);
      if (x < 0) quad_z = (y >= 0) ? Ang180 : -Ang180;
      else       quad_z = '0;
   endfunction

   function automatic logic signed [15:0] round_sat(input logic signed [AngW-1:0] a,
                                                    input logic signed [15:0] lim);
      logic signed [AngW-1:0] r;
      r = (a + (AngW'(1) <<< (AngFrac-1))) >>> AngFrac;
      if (r > AngW'(lim))       round_sat = lim;
      else if (r < -AngW'(lim)) round_sat = -lim;
      else                      round_sat = r[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NSt; s++) v_ff[s] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < NSt; s++) v_ff[s] <= v_ff[s-1];
      end
      if (adv) begin
         // stage 0: quadrant fold and zero-operand flags
         dg_ff[0]    <= in_word.degen;
         t_ff[0]     <= in_word.pitch_t;
         rzero_ff[0] <= (in_word.roll_x == '0) && (in_word.roll_y == '0);
         yzero_ff[0] <= (in_word.yaw_x == '0) && (in_word.yaw_y == '0);
         rz_ff[0]    <= quad_z(ry_op, rx_op);
         rx_ff[0]    <= (rx_op < 0) ? -rx_op : rx_op;
         ry_ff[0]    <= (rx_op < 0) ? -ry_op : ry_op;
         yz_ff[0]    <= quad_z(yy_op, yx_op);
         yx_ff[0]    <= (yx_op < 0) ? -yx_op : yx_op;
         yy_ff[0]    <= (yx_op < 0) ? -yy_op : yy_op;

         // side-band flags ride along the pipe
         for (int s = 1; s < NSt; s++) begin
            dg_ff[s]    <= dg_ff[s-1];
            rzero_ff[s] <= rzero_ff[s-1];
            yzero_ff[s] <= yzero_ff[s-1];
         end
         for (int s = 1; s <= CordicSteps; s++) t_ff[s] <= t_ff[s-1];

         // roll and yaw steps
         for (int i = 0; i < CordicSteps; i++) begin
            if (ry_ff[i] >= 0) begin
               rx_ff[i+1] <= rx_ff[i] + (ry_ff[i] >>> i);
               ry_ff[i+1] <= ry_ff[i] - (rx_ff[i] >>> i);
               rz_ff[i+1] <= rz_ff[i] + atan_entry(i);
            end else begin
               rx_ff[i+1] <= rx_ff[i] - (ry_ff[i] >>> i);
               ry_ff[i+1] <= ry_ff[i] + (rx_ff[i] >>> i);
               rz_ff[i+1] <= rz_ff[i] - atan_entry(i);
            end
            if (yy_ff[i] >= 0) begin
               yx_ff[i+1] <= yx_ff[i] + (yy_ff[i] >>> i);
               yy_ff[i+1] <= yy_ff[i] - (yx_ff[i] >>> i);
               yz_ff[i+1] <= yz_ff[i] + atan_entry(i);
            end else begin
               yx_ff[i+1] <= yx_ff[i] - (yy_ff[i] >>> i);
               yy_ff[i+1] <= yy_ff[i] + (yx_ff[i] >>> i);
               yz_ff[i+1] <= yz_ff[i] - atan_entry(i);
            end
         end

         // roll and yaw angles wait for pitch
         for (int s = CordicSteps+1; s < NSt; s++) begin
            rz_ff[s] <= rz_ff[s-1];
            yz_ff[s] <= yz_ff[s-1];
         end

         // stage 26: pitch operand times gain (37 x 21 bits), hypot from roll
         py_ff[0]    <= (OpW'(t_ff[CordicSteps]) * GainQ20) <<< 4;
         px_ff[0]    <= rzero_ff[CordicSteps] ? '0 : rx_ff[CordicSteps];
         pz_ff[0]    <= '0;
         pzero_ff[0] <= (t_ff[CordicSteps] == '0) && (rx_ff[CordicSteps] == '0);
         for (int k = 1; k < PSt; k++) pzero_ff[k] <= pzero_ff[k-1];

         // stage 27: quadrant (x is a magnitude, never negative)
         px_ff[1] <= px_ff[0];
         py_ff[1] <= py_ff[0];
         pz_ff[1] <= pz_ff[0];

         // pitch steps
         for (int i = 0; i < CordicSteps; i++) begin
            if (py_ff[i+1] >= 0) begin
               px_ff[i+2] <= px_ff[i+1] + (py_ff[i+1] >>> i);
               py_ff[i+2] <= py_ff[i+1] - (px_ff[i+1] >>> i);
               pz_ff[i+2] <= pz_ff[i+1] + atan_entry(i);
            end else begin
               px_ff[i+2] <= px_ff[i+1] - (py_ff[i+1] >>> i);
               py_ff[i+2] <= py_ff[i+1] + (px_ff[i+1] >>> i);
               pz_ff[i+2] <= pz_ff[i+1] - atan_entry(i);
            end
         end
         pz_ff[PSt-1] <= pz_ff[PSt-2];
      end
   end

   // output register
   logic signed [AngW-1:0] ra, pa, ya;
   assign ra = rzero_ff[NSt-1] ? '0 : rz_ff[NSt-1];
   assign ya = yzero_ff[NSt-1] ? '0 : yz_ff[NSt-1];
   assign pa = pzero_ff[PSt-1] ? '0 : pz_ff[PSt-1];
   assign rsp_valid       = v_ff[NSt-1];
   assign rsp_degenerate  = dg_ff[NSt-1];
   assign rsp_roll_angle  = dg_ff[NSt-1] ? '0 : round_sat(ra, 16'sd18000);
   assign rsp_yaw_angle   = dg_ff[NSt-1] ? '0 : round_sat(ya, 16'sd18000);
   assign rsp_pitch_angle = dg_ff[NSt-1] ? '0 : 15'(round_sat(pa, 16'sd9000));

   `Q2E_ASSERT(a_stall_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid)
   `Q2E_ASSERT(a_degen_zero, clock, reset, (rsp_valid && rsp_degenerate) |-> (rsp_roll_angle == '0 && rsp_yaw_angle == '0 && rsp_pitch_angle == '0))
   `Q2E_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_valid)
endmodule
`default_nettype wire

### rtl/quaternion_to_euler.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Raw attitude quaternion to roll, pitch and yaw in hundredths of a degree.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel takes one quaternion word (four signed components) when
//   req_valid is high and req_stall is low. rsp_ channel gives one result
//   word per request, in order, with roll, pitch, yaw and a degenerate flag
//   (all-zero input, angles zero).
//   Throughput: one word per cycle while rsp_stall is low. A word passes 2
//   front stages, the queue and 54 back stages. The depth is set by the
//   two chained 25-step CORDIC pipes (pitch needs roll's hypot).
//   A stalled rsp_ holds the back pipe; the 4-entry queue absorbs the front,
//   then req_stall rises. Reset empties all pipes and the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_to_euler import q2e_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [QuatBits-1:0] req_quat_w,
   input  wire logic signed [QuatBits-1:0] req_quat_x,
   input  wire logic signed [QuatBits-1:0] req_quat_y,
   input  wire logic signed [QuatBits-1:0] req_quat_z,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic signed [15:0]              rsp_roll_angle,
   output logic signed [14:0]              rsp_pitch_angle,
   output logic signed [15:0]              rsp_yaw_angle,
   output logic                            rsp_degenerate
);
   logic     f_valid, f_stall, b_valid, b_stall;
   work_type f_word, b_word;

   q2e_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_quat_w, .req_quat_x,
      .req_quat_y, .req_quat_z,
      .out_valid(f_valid), .out_stall(f_stall), .out_word(f_word));

   q2e_fifo u_fifo (
      .clock, .reset, .wr_valid(f_valid), .wr_stall(f_stall), .wr_word(f_word),
      .rd_valid(b_valid), .rd_stall(b_stall), .rd_word(b_word));

   q2e_back u_back (
      .clock, .reset, .in_valid(b_valid), .in_stall(b_stall), .in_word(b_word),
      .rsp_valid, .rsp_stall, .rsp_roll_angle, .rsp_pitch_angle,
      .rsp_yaw_angle, .rsp_degenerate);
endmodule
`default_nettype wire

### tb/sv/quaternion_to_euler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_checker
// Watches both channels of the quaternion to Euler block, computes the angles
// each accepted quaternion should give, and compares them in order with the
// result words. Hands the running error count to the testbench top.
// ----------------------------------------------------------------------------
module quaternion_to_euler_checker import q2e_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire logic signed [QuatBits-1:0] req_quat_w,
   input  wire logic signed [QuatBits-1:0] req_quat_x,
   input  wire logic signed [QuatBits-1:0] req_quat_y,
   input  wire logic signed [QuatBits-1:0] req_quat_z,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire logic signed [15:0]         rsp_roll_angle,
   input  wire logic signed [14:0]         rsp_pitch_angle,
   input  wire logic signed [15:0]         rsp_yaw_angle,
   input  wire logic                       rsp_degenerate,
   output int                              error_count,
   output int                              pending_count
);
   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic               degen;
   } angles_type;

   angles_type angles_due[$];

   // angle step table, 1/4096 centidegree units
   localparam longint StepAngle [CordicSteps] = '{
      18432000, 10881045, 5749245, 2918407, 1464867, 733147, 366663,
      183343, 91673, 45837, 22918, 11459, 5730, 2865, 1432, 716, 358,
      179, 90, 45, 22, 11, 6, 3, 1};

   // vectoring-mode rotation; mag gets gain times hypot
   function automatic longint vector_angle(input longint vy, input longint vx,
                                           output longint mag);
      longint acc, nx, ny;
      acc = 0;
      mag = 0;
      if (vx == 0 && vy == 0) return 0;
      if (vx < 0) begin
         acc = (vy >= 0) ? 64'sd73728000 : -64'sd73728000;
         vx = -vx;
         vy = -vy;
      end
      for (int i = 0; i < CordicSteps; i++) begin
         if (vy >= 0) begin
            nx = vx + (vy >>> i);
            ny = vy - (vx >>> i);
            acc += StepAngle[i];
         end else begin
            nx = vx - (vy >>> i);
            ny = vy + (vx >>> i);
            acc -= StepAngle[i];
         end
         vx = nx;
         vy = ny;
      end
      mag = vx;
      return acc;
   endfunction

   function automatic longint to_centideg(input longint a, input longint lim);
      longint r;
      r = (a + 2048) >>> AngFrac;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic angles_type euler_of(input logic signed [15:0] qw,
      input logic signed [15:0] qx, input logic signed [15:0] qy,
      input logic signed [15:0] qz);
      angles_type e;
      longint w, x, y, z, n2, ry, rx, yy, yx, t, mag, unused;
      longint roll, pitch, yaw;
      e = '0;
      if (qw == 0 && qx == 0 && qy == 0 && qz == 0) begin
         e.degen = 1'b1;
         return e;
      end
      w = qw; x = qx; y = qy; z = qz;
      n2 = w*w + x*x + y*y + z*z;
      ry = 2 * (w*x + y*z);
      rx = n2 - 2 * (x*x + y*y);
      yy = 2 * (w*z + x*y);
      yx = n2 - 2 * (y*y + z*z);
      t  = 2 * (w*y - z*x);
      roll  = vector_angle(ry <<< 24, rx <<< 24, mag);
      yaw   = vector_angle(yy <<< 24, yx <<< 24, unused);
      pitch = vector_angle((t * 64'sd1726753) <<< 4, mag, unused);
      e.roll  = 16'(to_centideg(roll, 18000));
      e.pitch = 15'(to_centideg(pitch, 9000));
      e.yaw   = 16'(to_centideg(yaw, 18000));
      return e;
   endfunction

   assign pending_count = angles_due.size();

   // predict on request, compare on response
   always @(posedge clock) begin
      angles_type want;
      if (reset) begin
         angles_due.delete();
         error_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            angles_due.push_back(euler_of(req_quat_w, req_quat_x, req_quat_y,
                                          req_quat_z));
         if (rsp_valid && !rsp_stall) begin
            if (angles_due.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected result word: roll %0d pitch %0d yaw %0d",
                           rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle);
               error_count <= error_count + 1;
            end else begin
               want = angles_due.pop_front();
               if (want.roll !== rsp_roll_angle || want.pitch !== rsp_pitch_angle
                   || want.yaw !== rsp_yaw_angle || want.degen !== rsp_degenerate)
               begin
                  if (error_count < 10)
                     $display("mismatch: exp r %0d p %0d y %0d d %0b, got r %0d p %0d y %0d d %0b",
                              want.roll, want.pitch, want.yaw, want.degen,
                              rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle,
                              rsp_degenerate);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

### tb/sv/quaternion_to_euler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_tb
// Drives directed and random quaternions into the block with random idling on
// both sides, a long output hold-off and a full drain, and reports the verdict
// from the checker's error and pending counts.
// ----------------------------------------------------------------------------
module quaternion_to_euler_tb;
   import q2e_pkg::*;

   localparam int DrainCycles = 200;
   localparam int StuckLimit  = 2000;
   localparam int RandomWords = 480;
   localparam int HoldWords   = 100;
   localparam int HoldCycles  = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [QuatBits-1:0] req_quat_w = '0, req_quat_x = '0;
   logic signed [QuatBits-1:0] req_quat_y = '0, req_quat_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_roll_angle, rsp_yaw_angle;
   logic signed [14:0] rsp_pitch_angle;
   logic rsp_degenerate;
   int error_count, pending_count;
   bit quiet_phase = 0;
   bit hold_request = 0;
   int idle_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   quaternion_to_euler dut (.*);
   quaternion_to_euler_checker u_checker (.*);

   // offer one word and wait until it is taken, with an optional gap first
   task automatic send_word(input logic [15:0] w, x, y, z);
      int gap;
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_quat_w <= w;
      req_quat_x <= x;
      req_quat_y <= y;
      req_quat_z <= z;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_all;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int burst;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_request = 0;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 12);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StuckLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [15:0] c [4];
      logic [15:0] a;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero, identity, extremes, gimbal lock, 180 deg cases
      send_word(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_word(16'h4000, 16'h0000, 16'h0000, 16'h0000);
      send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      send_word(16'h0000, 16'h0001, 16'h0000, 16'h0000);
      send_word(16'h0000, 16'h0000, 16'h0000, 16'h8000);
      send_word(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
      send_word(16'h1000, 16'h0000, 16'h1000, 16'h0000);
      send_word(16'h1000, 16'h0000, 16'hF000, 16'h0000);
      send_word(16'h1000, 16'h1000, 16'h1000, 16'h1000);
      send_word(16'h1000, 16'hF000, 16'h1000, 16'hF000);
      send_word(16'h0001, 16'h0000, 16'h0000, 16'h0000);
      send_word(16'hFFFF, 16'h0000, 16'h0000, 16'h0001);
      send_word(16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
      send_word(16'h5A82, 16'h5A82, 16'h0000, 16'h0000);

      // sender pauses until everything is back
      drain_all();

      // long receiver hold-off while the sender keeps offering; more words
      // than the pipe and queue hold, so req_stall has to rise
      hold_request = 1;
      repeat (HoldWords)
         send_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));

      // random: full range, small values, extremes, near-zero, all-zero and gimbal-like mixes
      for (int n = 0; n < RandomWords; n++) begin
         if (n == RandomWords - 80) quiet_phase = 1;
         for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 4))
               0: c[k] = 16'($urandom_range(0, 65535));
               1: c[k] = 16'($signed($urandom_range(0, 6)) - 3);
               2: c[k] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
               default: c[k] = 16'($urandom);
            endcase
         end
         if ($urandom_range(0, 9) == 0) begin
            // gimbal lock: w = +-y, x = -+z
            a = 16'($urandom);
            c[0] = a;
            c[2] = $urandom_range(0, 1) ? a : -a;
            c[1] = 16'($urandom);
            c[3] = (c[2] == c[0]) ? -c[1] : c[1];
         end
         if ($urandom_range(0, 39) == 0) c = '{default: 16'h0000};
         send_word(c[0], c[1], c[2], c[3]);
      end

      drain_all();
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

### quaternion_to_euler.f
+incdir+rtl
rtl/q2e_pkg.sv
rtl/q2e_front.sv
rtl/q2e_fifo.sv
rtl/q2e_back.sv
rtl/quaternion_to_euler.sv
tb/sv/quaternion_to_euler_checker.sv
tb/sv/quaternion_to_euler_tb.sv
